@@ design/baro_pressure_temp_compensation_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the baro pressure/temperature compensation block
// ----------------------------------------------------------------------------
`ifndef BARO_PRESSURE_TEMP_COMPENSATION_DEFINES_SVH
`define BARO_PRESSURE_TEMP_COMPENSATION_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define BPTC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define BPTC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/baro_ptc_pkg.sv @@
// ----------------------------------------------------------------------------
// baro_ptc_pkg
// Shared types and constants of the pressure/temperature compensation block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package baro_ptc_pkg;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int CAL_HI_W    = 40;
    localparam int RAW_W       = 24;
    localparam int IN_W        = 48;
    localparam int OUT_W       = 64;
    localparam int PIPE_STAGES = 19;

    localparam logic signed [63:0] TEMP_MAX = 64'sd2147483647;
    localparam logic signed [63:0] TEMP_MIN = -64'sd2147483648;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAL_LO  = 2'd0,
        CFG_CAL_MID = 2'd1,
        CFG_CAL_HI  = 2'd2
    } t_cfg_idx;

    // unpacked calibration coefficients; p1m/p2m already carry the -16384 offset
    typedef struct packed {
        logic        [15:0] t1;
        logic        [15:0] t2;
        logic signed [7:0]  t3;
        logic signed [16:0] p1m;
        logic signed [16:0] p2m;
        logic signed [7:0]  p3;
        logic signed [7:0]  p4;
        logic        [15:0] p5;
        logic        [15:0] p6;
        logic signed [7:0]  p7;
        logic signed [7:0]  p8;
        logic signed [15:0] p9;
        logic signed [7:0]  p10;
        logic signed [7:0]  p11;
    } t_coef;

endpackage

@@ design/baro_pressure_temp_compensation.sv @@
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation
// Integer compensation of raw pressure and temperature samples.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one beat carries a raw pressure and a raw temperature.
//   Output stream m_*: one beat per input beat, in order, with temperature
//   in 0.01 degC, pressure in 0.01 Pa and a clip flag on m_tuser.
//   Calibration: three writes through i_cfg_we/i_cfg_idx/i_cfg_data load the
//   21 calibration bytes; write them while no beat is in flight.
//   Pipeline: the beat crosses 19 register stages, the first loaded at the
//   accepting edge, and m_tvalid rises when it reaches the last (one multiply
//   or one 64-bit add per path and stage).
//   Throughput: one beat per cycle while the output is not stalled.
//   Reset: valid bits of all stages and the calibration registers clear and
//   s_tready is held low; the first beat can be taken in the cycle after
//   reset is released.
//   Stall: while m_tready is low the last stage holds its beat; upstream
//   stages keep filling bubbles, so s_tready only drops once every stage
//   holds a beat. Nothing is lost or repeated.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "baro_pressure_temp_compensation_defines.svh"

module baro_pressure_temp_compensation (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [baro_ptc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [baro_ptc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // [23:0] raw_pressure, [47:24] raw_temperature
    input  logic [baro_ptc_pkg::IN_W-1:0]        s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [31:0] temp_centi_deg, [63:32] press_centi_pa
    output logic [baro_ptc_pkg::OUT_W-1:0]       m_tdata,
    // [0] saturated
    output logic                                 m_tuser
);

    localparam int NS = baro_ptc_pkg::PIPE_STAGES;

    // signed division by 2^sh, truncating toward zero
    function automatic logic signed [63:0] f_sdiv(input logic signed [63:0] a,
                                                  input int unsigned sh);
        logic signed [63:0] bias;
        bias = a[63] ? ((64'sd1 <<< sh) - 64'sd1) : 64'sd0;
        return (a + bias) >>> sh;
    endfunction

    baro_ptc_pkg::t_coef w_coef;

    logic [NS-1:0]                  w_ld;
    logic [NS-1:0]                  r_v;
    logic [baro_ptc_pkg::RAW_W-1:0] w_rp;
    logic [baro_ptc_pkg::RAW_W-1:0] w_rt;

    // raw pressure travels alongside until its last use
    logic [baro_ptc_pkg::RAW_W-1:0] r_rp [0:14];

    // temperature path
    logic signed [24:0] r_d1t;
    logic        [47:0] r_rr;
    logic signed [41:0] r_t2d;
    logic signed [49:0] r_d1sq;
    logic signed [56:0] r_p11r;
    logic signed [57:0] r_t3m;
    logic signed [41:0] r_t2d2;
    logic signed [40:0] r_p11q;
    logic signed [59:0] r_d5;
    logic signed [63:0] r_p11x;
    logic signed [28:0] r_tf;
    logic signed [56:0] r_p11d [4:11];
    logic        [54:0] r_tf2;
    logic signed [33:0] r_tt25;
    logic signed [45:0] r_p6tf [5:11];
    logic signed [45:0] r_p2tf [5:11];
    logic signed [36:0] r_p10tf;
    logic signed [28:0] r_tf5;
    logic signed [20:0] r_ct6;
    logic        [31:0] r_tc [7:NS-1];
    logic               r_sat [7:NS-1];
    logic               w_ct_hi;
    logic               w_ct_lo;

    // pressure path
    logic signed [53:0] r_q1;
    logic signed [54:0] r_q2;
    logic signed [36:0] r_p7lo;
    logic signed [35:0] r_p7hi;
    logic signed [36:0] r_p3lo;
    logic signed [35:0] r_p3hi;
    logic signed [37:0] r_d3b;
    logic signed [63:0] r_pq;
    logic signed [63:0] r_d5o [7:11];
    logic signed [63:0] r_d4s [7:11];
    logic signed [62:0] r_pb;
    logic signed [55:0] r_d3;
    logic signed [49:0] r_d4r;
    logic signed [36:0] r_p8lo;
    logic signed [35:0] r_p8hi;
    logic signed [36:0] r_p4lo;
    logic signed [35:0] r_p4hi;
    logic signed [50:0] r_rlo;
    logic signed [49:0] r_rhi;
    logic signed [63:0] r_m8;
    logic signed [63:0] r_m4;
    logic signed [63:0] r_pr5;
    logic signed [63:0] r_d4o;
    logic signed [63:0] r_d2s;
    logic signed [63:0] r_d5r;
    logic signed [63:0] r_offa;
    logic signed [63:0] r_offb;
    logic signed [63:0] r_sena;
    logic signed [63:0] r_senb;
    logic signed [63:0] r_pa [12:14];
    logic signed [63:0] r_off;
    logic signed [63:0] r_sens;
    logic signed [63:0] r_offq;
    logic signed [39:0] r_sq;
    logic signed [63:0] r_d1p;
    logic signed [63:0] r_pb2;
    logic signed [63:0] r_d4;
    logic signed [63:0] r_d4x24;
    logic signed [63:0] r_d4c;
    logic        [63:0] w_sum25;
    logic        [23:0] r_cp;

    baro_ptc_calib u_calib (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_coef     (w_coef)
    );

    assign w_rp = s_tdata[23:0];
    assign w_rt = s_tdata[47:24];

    // a stage loads when the output is taken or when it, or any stage after it, has room
    for (genvar g = 0; g < NS; g++) begin : g_ld
        assign w_ld[g] = m_tready || !(&r_v[NS-1:g]);
    end

    assign s_tready = i_rst_n && w_ld[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_ld[0]) begin
                r_v[0] <= s_tvalid;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_ld[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    assign w_ct_hi = 64'(r_ct6) > baro_ptc_pkg::TEMP_MAX;
    assign w_ct_lo = 64'(r_ct6) < baro_ptc_pkg::TEMP_MIN;
    assign w_sum25 = r_d4x24 + r_d4c;

    // datapath stages; the carry chains shift alongside
    always_ff @(posedge i_clk) begin
        for (int k = 1; k <= 14; k++) begin
            if (w_ld[k]) r_rp[k] <= r_rp[k-1];
        end
        for (int k = 5; k <= 11; k++) begin
            if (w_ld[k]) r_p11d[k] <= r_p11d[k-1];
        end
        for (int k = 6; k <= 11; k++) begin
            if (w_ld[k]) begin
                r_p6tf[k] <= r_p6tf[k-1];
                r_p2tf[k] <= r_p2tf[k-1];
            end
        end
        for (int k = 8; k <= 11; k++) begin
            if (w_ld[k]) begin
                r_d5o[k] <= r_d5o[k-1];
                r_d4s[k] <= r_d4s[k-1];
            end
        end
        for (int k = 8; k < NS; k++) begin
            if (w_ld[k]) begin
                r_tc[k]  <= r_tc[k-1];
                r_sat[k] <= r_sat[k-1];
            end
        end
        for (int k = 13; k <= 14; k++) begin
            if (w_ld[k]) r_pa[k] <= r_pa[k-1];
        end

        if (w_ld[0]) begin
            r_rp[0] <= w_rp;
            r_d1t   <= $signed({1'b0, w_rt}) - $signed({1'b0, w_coef.t1, 8'h00});
            r_rr    <= w_rp * w_rp;
        end
        if (w_ld[1]) begin
            r_t2d  <= $signed({1'b0, w_coef.t2}) * r_d1t;
            r_d1sq <= r_d1t * r_d1t;
            r_p11r <= w_coef.p11 * $signed({1'b0, r_rr});
        end
        if (w_ld[2]) begin
            r_t3m  <= w_coef.t3 * r_d1sq;
            r_t2d2 <= r_t2d;
            r_p11q <= 41'(f_sdiv(64'(r_p11r), 16));
        end
        if (w_ld[3]) begin
            r_d5   <= (60'(r_t2d2) <<< 18) + 60'(r_t3m);
            r_p11x <= r_p11q * $signed({1'b0, r_rp[2]});
        end
        if (w_ld[4]) begin
            r_tf      <= 29'(f_sdiv(64'(r_d5), 32));
            r_p11d[4] <= 57'(f_sdiv(r_p11x, 7));
        end
        if (w_ld[5]) begin
            r_tf2     <= r_tf * r_tf;
            r_tt25    <= r_tf * 34'sd25;
            r_p6tf[5] <= $signed({1'b0, w_coef.p6}) * r_tf;
            r_p2tf[5] <= w_coef.p2m * r_tf;
            r_p10tf   <= w_coef.p10 * r_tf;
            r_tf5     <= r_tf;
        end
        if (w_ld[6]) begin
            // (tf*tf >> 6) * tf, split so that each product stays narrow
            r_q1   <= $signed({1'b0, r_tf2[29:6]}) * r_tf5;
            r_q2   <= $signed({1'b0, r_tf2[54:30]}) * r_tf5;
            r_p7lo <= w_coef.p7 * $signed({1'b0, r_tf2[27:0]});
            r_p7hi <= w_coef.p7 * $signed({1'b0, r_tf2[54:28]});
            r_p3lo <= w_coef.p3 * $signed({1'b0, r_tf2[27:0]});
            r_p3hi <= w_coef.p3 * $signed({1'b0, r_tf2[54:28]});
            r_ct6  <= 21'(f_sdiv(64'(r_tt25), 14));
            r_d3b  <= 38'(r_p10tf) + (38'(w_coef.p9) <<< 16);
        end
        if (w_ld[7]) begin
            r_pq     <= (64'(r_q2) <<< 24) + 64'(r_q1);
            r_d5o[7] <= ((64'(r_p7hi) <<< 28) + 64'(r_p7lo)) <<< 4;
            r_d4s[7] <= ((64'(r_p3hi) <<< 28) + 64'(r_p3lo)) <<< 2;
            r_pb     <= r_d3b * $signed({1'b0, r_rp[6]});
            r_tc[7]  <= w_ct_hi ? 32'h7fff_ffff :
                        w_ct_lo ? 32'h8000_0000 : 32'(r_ct6);
            r_sat[7] <= w_ct_hi || w_ct_lo;
        end
        if (w_ld[8]) begin
            r_d3  <= 56'(f_sdiv(r_pq, 8));
            r_d4r <= 50'(f_sdiv(64'(r_pb), 13));
        end
        if (w_ld[9]) begin
            r_p8lo <= w_coef.p8 * $signed({1'b0, r_d3[27:0]});
            r_p8hi <= w_coef.p8 * $signed(r_d3[55:28]);
            r_p4lo <= w_coef.p4 * $signed({1'b0, r_d3[27:0]});
            r_p4hi <= w_coef.p4 * $signed(r_d3[55:28]);
            r_rlo  <= $signed({1'b0, r_d4r[24:0]}) * $signed({1'b0, r_rp[8]});
            r_rhi  <= $signed(r_d4r[49:25]) * $signed({1'b0, r_rp[8]});
        end
        if (w_ld[10]) begin
            r_m8  <= (64'(r_p8hi) <<< 28) + 64'(r_p8lo);
            r_m4  <= (64'(r_p4hi) <<< 28) + 64'(r_p4lo);
            r_pr5 <= (64'(r_rhi) <<< 25) + 64'(r_rlo);
        end
        if (w_ld[11]) begin
            r_d4o <= f_sdiv(r_m8, 5);
            r_d2s <= f_sdiv(r_m4, 5);
            r_d5r <= f_sdiv(r_pr5, 9);
        end
        if (w_ld[12]) begin
            r_offa   <= ($signed(64'(w_coef.p5)) <<< 47) + (64'(r_p6tf[11]) <<< 22);
            r_offb   <= r_d4o + r_d5o[11];
            r_sena   <= (64'(w_coef.p1m) <<< 46) + (64'(r_p2tf[11]) <<< 21);
            r_senb   <= r_d2s + r_d4s[11];
            r_pa[12] <= r_d5r + 64'(r_p11d[11]);
        end
        if (w_ld[13]) begin
            r_off  <= r_offa + r_offb;
            r_sens <= r_sena + r_senb;
        end
        if (w_ld[14]) begin
            r_offq <= f_sdiv(r_off, 2);
            r_sq   <= 40'(f_sdiv(r_sens, 24));
        end
        if (w_ld[15]) begin
            r_d1p <= r_sq * $signed({1'b0, r_rp[14]});
            r_pb2 <= r_offq + r_pa[14];
        end
        if (w_ld[16]) begin
            r_d4 <= r_d1p + r_pb2;
        end
        if (w_ld[17]) begin
            r_d4x24 <= (r_d4 <<< 4) + (r_d4 <<< 3);
            r_d4c   <= r_d4;
        end
        if (w_ld[18]) begin
            // unsigned 64-bit (x*25) >> 40 stays below 2^24, so it never clips
            r_cp <= w_sum25[63:40];
        end
    end

    assign m_tvalid = r_v[NS-1];
    assign m_tdata  = {8'h00, r_cp, r_tc[NS-1]};
    assign m_tuser  = r_sat[NS-1];

    `BPTC_ASSERT_NXT(a_in_lands, i_clk, i_rst_n, s_tvalid && s_tready, r_v[0],
        "accepted beat did not enter the first stage")
    `BPTC_ASSERT_NXT(a_stage0_hold, i_clk, i_rst_n, r_v[0] && !w_ld[1], r_v[0],
        "beat in the first stage dropped while the next stage was blocked")
    `BPTC_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, r_v[NS-2] && r_v[NS-1] && !m_tready,
        r_v[NS-2] && $stable(r_d4x24) && $stable(r_cp),
        "stalled pipeline tail changed")
    `BPTC_ASSERT_IMP(a_sat_clip, i_clk, i_rst_n, m_tvalid && m_tuser,
        m_tdata[31:0] == 32'h7fff_ffff || m_tdata[31:0] == 32'h8000_0000,
        "clip flag set without a clipped temperature")

endmodule

@@ design/baro_ptc_calib.sv @@
// ----------------------------------------------------------------------------
// baro_ptc_calib
// Calibration byte registers and their unpacking into coefficients.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module baro_ptc_calib (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [baro_ptc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [baro_ptc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output baro_ptc_pkg::t_coef                  o_coef
);

    logic [63:0]                       r_cal_lo;
    logic [63:0]                       r_cal_mid;
    logic [baro_ptc_pkg::CAL_HI_W-1:0] r_cal_hi;
    logic [167:0]                      w_cal;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_lo  <= '0;
            r_cal_mid <= '0;
            r_cal_hi  <= '0;
        end else if (i_cfg_we) begin
            case (baro_ptc_pkg::t_cfg_idx'(i_cfg_idx))
                baro_ptc_pkg::CFG_CAL_LO: begin
                    r_cal_lo <= i_cfg_data;
                end
                baro_ptc_pkg::CFG_CAL_MID: begin
                    r_cal_mid <= i_cfg_data;
                end
                baro_ptc_pkg::CFG_CAL_HI: begin
                    r_cal_hi <= i_cfg_data[baro_ptc_pkg::CAL_HI_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // byte n of the calibration file sits at w_cal[8n+7:8n]
    assign w_cal = {r_cal_hi, r_cal_mid, r_cal_lo};

    assign o_coef.t1  = w_cal[15:0];
    assign o_coef.t2  = w_cal[31:16];
    assign o_coef.t3  = $signed(w_cal[39:32]);
    assign o_coef.p1m = $signed({w_cal[55], w_cal[55:40]}) - 17'sd16384;
    assign o_coef.p2m = $signed({w_cal[71], w_cal[71:56]}) - 17'sd16384;
    assign o_coef.p3  = $signed(w_cal[79:72]);
    assign o_coef.p4  = $signed(w_cal[87:80]);
    assign o_coef.p5  = w_cal[103:88];
    assign o_coef.p6  = w_cal[119:104];
    assign o_coef.p7  = $signed(w_cal[127:120]);
    assign o_coef.p8  = $signed(w_cal[135:128]);
    assign o_coef.p9  = $signed(w_cal[151:136]);
    assign o_coef.p10 = $signed(w_cal[159:152]);
    assign o_coef.p11 = $signed(w_cal[167:160]);

endmodule
